>>> src/att_pkg.sv
// shared constants, codes and transaction types of the allocation tracker
package att_pkg;

	localparam int HEAD_SLOTS  = 1024;
	localparam int POOL_SLOTS  = 1024;
	localparam int TOTAL_SLOTS = HEAD_SLOTS + POOL_SLOTS;

	localparam int HEAD_W = $clog2(HEAD_SLOTS);
	localparam int POOL_W = $clog2(POOL_SLOTS);
	localparam int ENT_W  = $clog2(TOTAL_SLOTS);
	localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
	localparam int LIVE_W = 12;
	localparam int ADDR_W = 64;
	localparam int SIZE_W = 48;
	localparam int ECNT_W = 32;
	localparam int SUM_W  = 64;

	localparam logic [63:0] HASH_SEED = 64'd2166136261;
	localparam logic [63:0] HASH_K1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] HASH_K2   = 64'hd6e8feb86659fd93;
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	typedef enum logic [1:0] {
		OP_MALLOC  = 2'd0,
		OP_CALLOC  = 2'd1,
		OP_FREE    = 2'd2,
		OP_REALLOC = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNTRACKED = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic              has_next;
		logic [ENT_W-1:0]  nxt;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] addr;
	} hash_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [HEAD_W-1:0] bucket;
	} hash_rsp_t;

	typedef struct packed {
		status_t           status;
		logic [SIZE_W-1:0] old_size;
		logic [LIVE_W-1:0] live;
		logic [LIVE_W-1:0] peak;
		logic [SUM_W-1:0]  total;
		logic [SUM_W-1:0]  allocated;
		logic [SUM_W-1:0]  released;
	} result_t;

endpackage

>>> src/att_hash.sv
// multi-cycle address hash: two 64-bit multiplies from 32x32 partial products
module att_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  att_pkg::hash_req_t  req,
	output att_pkg::hash_rsp_t  rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [2:0]                 cnt_q;
	logic [63:0]                x_q;
	logic [7:0]                 byte_q;
	logic [63:0]                acc_q;
	logic [63:0]                prod_q;
	logic [att_pkg::HEAD_W-1:0] bucket_q;

	logic [2:0]  j_iss;
	logic [2:0]  j_acc;
	logic [63:0] k_sel;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] acc_next;
	logic [63:0] folded;

	// counter values 0..2 issue the first multiply, 4..6 the second; each product accumulates in the next cycle
	always_comb begin
		k_sel = (cnt_q < 3'd3) ? att_pkg::HASH_K1 : att_pkg::HASH_K2;
		j_iss = (cnt_q < 3'd3) ? cnt_q : cnt_q - 3'd4;
		j_acc = (cnt_q < 3'd4) ? cnt_q - 3'd1 : cnt_q - 3'd5;
		case (j_iss)
			3'd0: begin
				op_a = x_q[31:0];
				op_b = k_sel[31:0];
			end
			3'd1: begin
				op_a = x_q[31:0];
				op_b = k_sel[63:32];
			end
			3'd2: begin
				op_a = x_q[63:32];
				op_b = k_sel[31:0];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		case (j_acc)
			3'd0:       acc_next = prod_q;
			3'd1, 3'd2: acc_next = acc_q + {prod_q[31:0], 32'd0};
			default:    acc_next = acc_q;
		endcase
		folded = acc_next ^ {32'd0, acc_next[63:32]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start && !done_q) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			x_q    <= att_pkg::HASH_SEED ^ req.addr;
			byte_q <= req.addr[7:0];
		end else begin
			prod_q <= op_a * op_b;
			acc_q  <= acc_next;
			if (cnt_q == 3'd3)
				x_q <= acc_next ^ {48'd0, byte_q, 8'h08};
			if (cnt_q == 3'd7)
				bucket_q <= folded[att_pkg::HEAD_W-1:0];
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.bucket = bucket_q;

endmodule

>>> src/att_table.sv
// table sequencer: entry and free-list memories, chain walks and running counts
module att_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  att_pkg::op_t                  op,
	input  logic [att_pkg::ADDR_W-1:0]    new_address,
	input  logic [att_pkg::ADDR_W-1:0]    old_address,
	input  logic [att_pkg::SIZE_W-1:0]    alloc_size,
	input  logic [att_pkg::ECNT_W-1:0]    element_count,
	output att_pkg::hash_req_t            hash_req,
	input  att_pkg::hash_rsp_t            hash_rsp,
	output logic                          res_valid,
	output att_pkg::result_t              res,
	input  logic                          out_free
);

	localparam int NS = 23;
	localparam int ENT_W = att_pkg::ENT_W;
	localparam int POOL_W = att_pkg::POOL_W;
	localparam int CNT_W = att_pkg::CNT_W;

	typedef enum logic [NS-1:0] {
		S_CLEAR   = 23'b1 << 0,
		S_IDLE    = 23'b1 << 1,
		S_MUL     = 23'b1 << 2,
		S_SAT     = 23'b1 << 3,
		S_HASH_O  = 23'b1 << 4,
		S_LK_RD   = 23'b1 << 5,
		S_LK_CHK  = 23'b1 << 6,
		S_POST    = 23'b1 << 7,
		S_HASH_N  = 23'b1 << 8,
		S_HN_RD   = 23'b1 << 9,
		S_HN_CHK  = 23'b1 << 10,
		S_RM      = 23'b1 << 11,
		S_RM_CPY  = 23'b1 << 12,
		S_REL     = 23'b1 << 13,
		S_RM_END  = 23'b1 << 14,
		S_AD_RD   = 23'b1 << 15,
		S_AD_CHK  = 23'b1 << 16,
		S_AD_FL   = 23'b1 << 17,
		S_AD_WALK = 23'b1 << 18,
		S_AD_WCHK = 23'b1 << 19,
		S_AD_NEW  = 23'b1 << 20,
		S_AD_END  = 23'b1 << 21,
		S_OUT     = 23'b1 << 22
	} state_t;

	att_pkg::entry_t ent_mem [att_pkg::TOTAL_SLOTS];
	logic [POOL_W-1:0] fl_mem [att_pkg::POOL_SLOTS];

	state_t                          state_q;
	logic [ENT_W-1:0]                clr_q;
	att_pkg::op_t                    op_q;
	logic [att_pkg::ADDR_W-1:0]      new_q;
	logic [att_pkg::ADDR_W-1:0]      old_q;
	logic [att_pkg::SIZE_W-1:0]      size_q;
	logic [att_pkg::ECNT_W-1:0]      ecnt_q;
	logic [63:0]                     plo_q;
	logic [47:0]                     phi_q;
	logic [att_pkg::HEAD_W-1:0]      hb_new_q;
	logic [ENT_W-1:0]                cur_q;
	logic                            first_q;
	logic                            found_q;
	logic [ENT_W-1:0]                idx_q;
	att_pkg::entry_t                 idx_word_q;
	logic                            has_prev_q;
	logic [ENT_W-1:0]                prev_q;
	att_pkg::entry_t                 prev_word_q;
	att_pkg::entry_t                 cur_word_q;
	logic [ENT_W-1:0]                e_q;
	logic [ENT_W-1:0]                rel_q;
	logic [CNT_W-1:0]                free_cnt_q;
	logic [att_pkg::LIVE_W-1:0]      live_q;
	logic [att_pkg::LIVE_W-1:0]      peak_q;
	logic [att_pkg::SUM_W-1:0]       events_q;
	logic [att_pkg::SUM_W-1:0]       sum_a_q;
	logic [att_pkg::SUM_W-1:0]       sum_r_q;
	att_pkg::status_t                status_q;
	logic [att_pkg::SIZE_W-1:0]      old_size_q;
	att_pkg::entry_t                 rd_q;
	logic [POOL_W-1:0]               fl_rd_q;

	logic                  ent_we;
	logic [ENT_W-1:0]      ent_waddr;
	att_pkg::entry_t       ent_wdata;
	logic                  ent_re;
	logic [ENT_W-1:0]      ent_raddr;
	logic                  fl_we;
	logic [POOL_W-1:0]     fl_waddr;
	logic [POOL_W-1:0]     fl_wdata;
	logic                  fl_re;
	logic [POOL_W-1:0]     fl_raddr;

	logic [79:0]           calloc_full;
	logic [CNT_W-1:0]      fc_dec;
	logic                  lone_head;
	logic                  in_place;
	logic                  pool_empty;
	logic                  rel_to_pool;
	att_pkg::entry_t       new_entry;
	logic [att_pkg::LIVE_W-1:0] live_inc;

	always_comb begin
		calloc_full = {16'd0, plo_q} + {phi_q, 32'd0};
		fc_dec      = free_cnt_q - CNT_W'(1);
		lone_head   = !has_prev_q && !idx_word_q.has_next;
		in_place    = found_q && (new_q == old_q);
		pool_empty  = (free_cnt_q == '0);
		rel_to_pool = (rel_q >= ENT_W'(att_pkg::HEAD_SLOTS))
			&& (free_cnt_q < CNT_W'(att_pkg::POOL_SLOTS));
		live_inc    = live_q + 1'b1;
		new_entry   = '{valid: 1'b1, has_next: 1'b0, nxt: '0, size: size_q, addr: new_q};
	end

	// memory port control
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = idx_q;
		ent_wdata = idx_word_q;
		ent_re    = 1'b0;
		ent_raddr = cur_q;
		fl_we     = 1'b0;
		fl_waddr  = free_cnt_q[POOL_W-1:0];
		fl_wdata  = POOL_W'(rel_q - ENT_W'(att_pkg::HEAD_SLOTS));
		fl_re     = 1'b0;
		fl_raddr  = fc_dec[POOL_W-1:0];
		case (state_q)
			S_CLEAR: begin
				ent_we    = 1'b1;
				ent_waddr = clr_q;
				ent_wdata = '0;
				fl_we     = (clr_q < ENT_W'(att_pkg::POOL_SLOTS));
				fl_waddr  = clr_q[POOL_W-1:0];
				fl_wdata  = clr_q[POOL_W-1:0];
			end
			S_LK_RD: ent_re = 1'b1;
			S_POST: begin
				if (op_q != att_pkg::OP_FREE && in_place) begin
					ent_we         = 1'b1;
					ent_wdata.size = size_q;
				end
			end
			S_HN_RD, S_AD_RD: begin
				ent_re    = 1'b1;
				ent_raddr = ENT_W'(hb_new_q);
			end
			S_RM: begin
				if (has_prev_q) begin
					ent_we             = 1'b1;
					ent_waddr          = prev_q;
					ent_wdata          = prev_word_q;
					ent_wdata.has_next = idx_word_q.has_next;
					ent_wdata.nxt      = idx_word_q.nxt;
				end else if (!idx_word_q.has_next) begin
					ent_we          = 1'b1;
					ent_wdata.valid = 1'b0;
				end else begin
					ent_re    = 1'b1;
					ent_raddr = idx_word_q.nxt;
				end
			end
			S_RM_CPY: begin
				ent_we          = 1'b1;
				ent_wdata       = rd_q;
				ent_wdata.valid = 1'b1;
			end
			S_REL: begin
				ent_we    = 1'b1;
				ent_waddr = rel_q;
				ent_wdata = '0;
				fl_we     = rel_to_pool;
			end
			S_AD_CHK: begin
				if (!rd_q.valid) begin
					ent_we    = 1'b1;
					ent_waddr = ENT_W'(hb_new_q);
					ent_wdata = new_entry;
				end else begin
					fl_re = 1'b1;
				end
			end
			S_AD_WALK: begin
				if (cur_word_q.has_next) begin
					ent_re    = 1'b1;
					ent_raddr = cur_word_q.nxt;
				end else begin
					ent_we             = 1'b1;
					ent_waddr          = cur_q;
					ent_wdata          = cur_word_q;
					ent_wdata.has_next = 1'b1;
					ent_wdata.nxt      = e_q;
				end
			end
			S_AD_NEW: begin
				ent_we    = 1'b1;
				ent_waddr = e_q;
				ent_wdata = new_entry;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_waddr] <= ent_wdata;
		if (ent_re)
			rd_q <= ent_mem[ent_raddr];
		if (fl_we)
			fl_mem[fl_waddr] <= fl_wdata;
		if (fl_re)
			fl_rd_q <= fl_mem[fl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			free_cnt_q <= CNT_W'(att_pkg::POOL_SLOTS);
			live_q     <= '0;
			peak_q     <= '0;
			events_q   <= '0;
			sum_a_q    <= '0;
			sum_r_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ENT_W'(att_pkg::TOTAL_SLOTS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q       <= op;
						new_q      <= new_address;
						old_q      <= old_address;
						size_q     <= alloc_size;
						ecnt_q     <= element_count;
						status_q   <= att_pkg::ST_OK;
						old_size_q <= '0;
						found_q    <= 1'b0;
						if (op == att_pkg::OP_CALLOC)
							state_q <= S_MUL;
						else if (op == att_pkg::OP_FREE
							|| (op == att_pkg::OP_REALLOC && old_address != '0))
							state_q <= S_HASH_O;
						else
							state_q <= S_HASH_N;
					end
				end
				S_MUL: begin
					plo_q   <= size_q[31:0] * ecnt_q;
					phi_q   <= size_q[47:32] * ecnt_q;
					state_q <= S_SAT;
				end
				S_SAT: begin
					size_q  <= (|calloc_full[79:48]) ? att_pkg::SIZE_MAX : calloc_full[47:0];
					state_q <= S_HASH_N;
				end
				S_HASH_O: begin
					if (hash_rsp.done) begin
						cur_q      <= ENT_W'(hash_rsp.bucket);
						has_prev_q <= 1'b0;
						first_q    <= 1'b1;
						state_q    <= S_LK_RD;
					end
				end
				S_LK_RD: state_q <= S_LK_CHK;
				S_LK_CHK: begin
					if (first_q && !rd_q.valid) begin
						state_q <= S_POST;
					end else if (rd_q.addr == old_q) begin
						found_q    <= 1'b1;
						idx_q      <= cur_q;
						idx_word_q <= rd_q;
						state_q    <= S_POST;
					end else if (rd_q.has_next) begin
						prev_q      <= cur_q;
						prev_word_q <= rd_q;
						has_prev_q  <= 1'b1;
						cur_q       <= rd_q.nxt;
						first_q     <= 1'b0;
						state_q     <= S_LK_RD;
					end else begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (op_q == att_pkg::OP_FREE) begin
						if (!found_q) begin
							status_q <= att_pkg::ST_UNTRACKED;
							state_q  <= S_OUT;
						end else begin
							old_size_q <= idx_word_q.size;
							sum_r_q    <= sum_r_q + att_pkg::SUM_W'(idx_word_q.size);
							state_q    <= S_RM;
						end
					end else if (in_place) begin
						old_size_q <= idx_word_q.size;
						if (size_q > idx_word_q.size)
							sum_a_q <= sum_a_q + att_pkg::SUM_W'(size_q - idx_word_q.size);
						else
							sum_r_q <= sum_r_q + att_pkg::SUM_W'(idx_word_q.size - size_q);
						events_q <= events_q + 1'b1;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_HASH_N;
					end
				end
				S_HASH_N: begin
					if (hash_rsp.done) begin
						hb_new_q <= hash_rsp.bucket;
						state_q  <= S_HN_RD;
					end
				end
				S_HN_RD: state_q <= S_HN_CHK;
				S_HN_CHK: begin
					if (found_q) begin
						old_size_q <= idx_word_q.size;
						// a moving realloc fails only if removal frees nothing usable
						if (pool_empty && rd_q.valid && lone_head
							&& ENT_W'(hb_new_q) != idx_q) begin
							status_q <= att_pkg::ST_POOL_FULL;
							state_q  <= S_OUT;
						end else begin
							sum_r_q <= sum_r_q + att_pkg::SUM_W'(idx_word_q.size);
							sum_a_q <= sum_a_q + att_pkg::SUM_W'(size_q);
							state_q <= S_RM;
						end
					end else if (pool_empty && rd_q.valid) begin
						status_q <= att_pkg::ST_POOL_FULL;
						state_q  <= S_OUT;
					end else begin
						sum_a_q <= sum_a_q + att_pkg::SUM_W'(size_q);
						state_q <= S_AD_RD;
					end
				end
				S_RM: begin
					if (has_prev_q) begin
						rel_q   <= idx_q;
						state_q <= S_REL;
					end else if (!idx_word_q.has_next) begin
						state_q <= S_RM_END;
					end else begin
						state_q <= S_RM_CPY;
					end
				end
				S_RM_CPY: begin
					rel_q   <= idx_word_q.nxt;
					state_q <= S_REL;
				end
				S_REL: begin
					if (rel_to_pool)
						free_cnt_q <= free_cnt_q + 1'b1;
					state_q <= S_RM_END;
				end
				S_RM_END: begin
					if (live_q != '0)
						live_q <= live_q - 1'b1;
					state_q <= (op_q == att_pkg::OP_FREE) ? S_OUT : S_AD_RD;
				end
				S_AD_RD: state_q <= S_AD_CHK;
				S_AD_CHK: begin
					if (!rd_q.valid) begin
						state_q <= S_AD_END;
					end else begin
						free_cnt_q <= fc_dec;
						cur_q      <= ENT_W'(hb_new_q);
						cur_word_q <= rd_q;
						state_q    <= S_AD_FL;
					end
				end
				S_AD_FL: begin
					e_q     <= ENT_W'(att_pkg::HEAD_SLOTS) + ENT_W'(fl_rd_q);
					state_q <= S_AD_WALK;
				end
				S_AD_WALK: begin
					if (cur_word_q.has_next) begin
						cur_q   <= cur_word_q.nxt;
						state_q <= S_AD_WCHK;
					end else begin
						state_q <= S_AD_NEW;
					end
				end
				S_AD_WCHK: begin
					cur_word_q <= rd_q;
					state_q    <= S_AD_WALK;
				end
				S_AD_NEW: state_q <= S_AD_END;
				S_AD_END: begin
					live_q   <= live_inc;
					if (live_inc > peak_q)
						peak_q <= live_inc;
					events_q <= events_q + 1'b1;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign hash_req.start = (state_q == S_HASH_O) || (state_q == S_HASH_N);
	assign hash_req.addr  = (state_q == S_HASH_O) ? old_q : new_q;
	assign res_valid     = (state_q == S_OUT);

	always_comb begin
		res.status    = status_q;
		res.old_size  = old_size_q;
		res.live      = live_q;
		res.peak      = peak_q;
		res.total     = events_q;
		res.allocated = sum_a_q;
		res.released  = sum_r_q;
	end

endmodule

>>> src/allocation_tracker_table_unit.sv
// an event walks its hash chains one entry at a time, so each extra chain entry walked delays the result
// each address hash runs on one shared 32x32 multiplier, done once or twice
// one event at a time, the next transaction can be taken in the cycle after the result is loaded
// a finished result waits in the output register while the next transaction is taken
// after reset a clearing pass initializes both memories, input held off
// arst_n resets all counters and control state at once, the free count to full
module allocation_tracker_table_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [207:0] s_tdata,  // new_address, old_address, alloc_size, element_count
	input  logic [1:0]   s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	// old_size, live_count, peak_live, total_count, bytes_allocated, bytes_freed,
	// bytes_outstanding
	output logic [327:0] m_tdata,
	output logic [1:0]   m_tuser   // status
);

	att_pkg::hash_req_t hash_req;
	att_pkg::hash_rsp_t hash_rsp;
	att_pkg::result_t   res;
	logic               res_valid;
	logic               in_ready;
	logic               out_free;
	logic               out_valid_q;
	logic [327:0]       out_data_q;
	logic [1:0]         out_user_q;

	att_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hash_req),
		.rsp    (hash_rsp)
	);

	att_table u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (in_ready),
		.op            (att_pkg::op_t'(s_tuser)),
		.new_address   (s_tdata[63:0]),
		.old_address   (s_tdata[127:64]),
		.alloc_size    (s_tdata[175:128]),
		.element_count (s_tdata[207:176]),
		.hash_req      (hash_req),
		.hash_rsp      (hash_rsp),
		.res_valid     (res_valid),
		.res           (res),
		.out_free      (out_free)
	);

	assign s_tready = in_ready;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_user_q <= res.status;
			out_data_q <= {res.allocated - res.released, res.released, res.allocated,
				res.total, res.peak, res.live, res.old_size};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an event is in progress");

	a_peak_covers_live: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:60] >= m_tdata[59:48])
		else $error("peak below live count");

	a_untracked_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == att_pkg::ST_UNTRACKED |-> m_tdata[47:0] == 48'd0)
		else $error("untracked free reports a size");

endmodule

>>> dv/tb_allocation_tracker_table_unit.sv
// testbench for the allocation tracker table: directed and random allocator events checked against a predictor
`timescale 1ns / 1ps
module tb_allocation_tracker_table_unit;

	typedef struct {
		att_pkg::op_t                      op;
		logic [att_pkg::ADDR_W-1:0]        new_addr;
		logic [att_pkg::ADDR_W-1:0]        old_addr;
		logic [att_pkg::SIZE_W-1:0]        size;
		logic [att_pkg::ECNT_W-1:0]        count;
	} event_t;

	typedef struct packed {
		att_pkg::status_t                  status;
		logic [att_pkg::SIZE_W-1:0]        old_size;
		logic [att_pkg::LIVE_W-1:0]        live;
		logic [att_pkg::LIVE_W-1:0]        peak;
		logic [att_pkg::SUM_W-1:0]         total;
		logic [att_pkg::SUM_W-1:0]         allocated;
		logic [att_pkg::SUM_W-1:0]         released;
		logic [att_pkg::SUM_W-1:0]         outstanding;
	} report_t;

	class tracker_scoreboard;
		logic [att_pkg::ADDR_W-1:0] slot_addr [att_pkg::TOTAL_SLOTS];
		logic [att_pkg::SIZE_W-1:0] slot_size [att_pkg::TOTAL_SLOTS];
		bit                slot_used [att_pkg::TOTAL_SLOTS];
		bit                slot_linked [att_pkg::TOTAL_SLOTS];
		int                slot_link [att_pkg::TOTAL_SLOTS];
		int                spare_stack [att_pkg::POOL_SLOTS];
		int                spare_count;
		int                live_now, live_max;
		logic [63:0]       event_total, alloc_sum, release_sum;
		report_t           pending [$];
		int                mismatches;

		function new();
			for (int i = 0; i < att_pkg::TOTAL_SLOTS; i++) begin
				slot_used[i] = 0;
				slot_linked[i] = 0;
				slot_link[i] = 0;
				slot_addr[i] = '0;
				slot_size[i] = '0;
			end
			for (int i = 0; i < att_pkg::POOL_SLOTS; i++) spare_stack[i] = i;
			spare_count = att_pkg::POOL_SLOTS;
			live_now = 0;
			live_max = 0;
			event_total = 0;
			alloc_sum = 0;
			release_sum = 0;
			mismatches = 0;
		endfunction

		function int bucket(logic [63:0] a);
			logic [63:0] h;
			h = att_pkg::HASH_SEED ^ a;
			h = h * att_pkg::HASH_K1;
			h = h ^ (64'd8 | {48'd0, a[7:0], 8'd0});
			h = h * att_pkg::HASH_K2;
			h = h ^ (h >> 32);
			return int'(h % att_pkg::HEAD_SLOTS);
		endfunction

		function int find(logic [63:0] a, output int prv);
			int cur;
			int prior;
			cur = bucket(a);
			prior = -1;
			prv = -1;
			if (!slot_used[cur]) return -1;
			for (int s = 0; s < att_pkg::TOTAL_SLOTS; s++) begin
				if (slot_addr[cur] == a) begin
					prv = prior;
					return cur;
				end
				if (!slot_linked[cur]) break;
				prior = cur;
				cur = slot_link[cur];
			end
			return -1;
		endfunction

		function void free_slot(int idx);
			slot_used[idx] = 0;
			slot_linked[idx] = 0;
			if (idx >= att_pkg::HEAD_SLOTS && spare_count < att_pkg::POOL_SLOTS) begin
				spare_stack[spare_count] = idx - att_pkg::HEAD_SLOTS;
				spare_count++;
			end
		endfunction

		function void unlink(int idx, int prv);
			int n;
			if (prv < 0) begin
				if (!slot_linked[idx]) slot_used[idx] = 0;
				else begin
					// pull the successor up into the head slot
					n = slot_link[idx];
					slot_addr[idx] = slot_addr[n];
					slot_size[idx] = slot_size[n];
					slot_linked[idx] = slot_linked[n];
					slot_link[idx] = slot_link[n];
					free_slot(n);
				end
			end else begin
				slot_linked[prv] = slot_linked[idx];
				slot_link[prv] = slot_link[idx];
				free_slot(idx);
			end
			if (live_now > 0) live_now--;
		endfunction

		function void insert(logic [63:0] a, logic [att_pkg::SIZE_W-1:0] sz);
			int h, e, cur;
			h = bucket(a);
			cur = h;
			if (!slot_used[h]) e = h;
			else begin
				spare_count--;
				e = att_pkg::HEAD_SLOTS + spare_stack[spare_count];
				for (int s = 0; s < att_pkg::TOTAL_SLOTS; s++) begin
					if (!slot_linked[cur]) break;
					cur = slot_link[cur];
				end
				slot_linked[cur] = 1;
				slot_link[cur] = e;
			end
			slot_addr[e] = a;
			slot_size[e] = sz;
			slot_used[e] = 1;
			slot_linked[e] = 0;
			live_now++;
			event_total++;
			if (live_now > live_max) live_max = live_now;
		endfunction

		function void note_event(event_t ev);
			report_t r;
			int idx, prv, hn;
			logic [att_pkg::SIZE_W-1:0] sz;
			logic [att_pkg::SIZE_W-1:0] prev_sz;
			logic [80:0] prod;
			bit lone;
			r.status = att_pkg::ST_OK;
			prev_sz = '0;
			sz = ev.size;
			if (ev.op == att_pkg::OP_FREE) begin
				idx = find(ev.old_addr, prv);
				if (idx < 0) r.status = att_pkg::ST_UNTRACKED;
				else begin
					prev_sz = slot_size[idx];
					release_sum += prev_sz;
					unlink(idx, prv);
				end
			end else begin
				if (ev.op == att_pkg::OP_CALLOC) begin
					prod = ev.size * ev.count;
					sz = (prod > {33'd0, att_pkg::SIZE_MAX}) ? att_pkg::SIZE_MAX
						: prod[att_pkg::SIZE_W-1:0];
				end
				idx = -1;
				if (ev.op == att_pkg::OP_REALLOC && ev.old_addr != 0)
					idx = find(ev.old_addr, prv);
				if (idx >= 0 && ev.new_addr == ev.old_addr) begin
					prev_sz = slot_size[idx];
					if (sz > prev_sz) alloc_sum += sz - prev_sz;
					else release_sum += prev_sz - sz;
					slot_size[idx] = sz;
					event_total++;
				end else if (idx >= 0) begin
					hn = bucket(ev.new_addr);
					lone = prv < 0 && !slot_linked[idx];
					prev_sz = slot_size[idx];
					if (spare_count == 0 && slot_used[hn] && lone && hn != idx)
						r.status = att_pkg::ST_POOL_FULL;
					else begin
						release_sum += prev_sz;
						alloc_sum += sz;
						unlink(idx, prv);
						insert(ev.new_addr, sz);
					end
				end else begin
					if (spare_count == 0 && slot_used[bucket(ev.new_addr)])
						r.status = att_pkg::ST_POOL_FULL;
					else begin
						alloc_sum += sz;
						insert(ev.new_addr, sz);
					end
				end
			end
			r.old_size = prev_sz;
			r.live = live_now[att_pkg::LIVE_W-1:0];
			r.peak = live_max[att_pkg::LIVE_W-1:0];
			r.total = event_total;
			r.allocated = alloc_sum;
			r.released = release_sum;
			r.outstanding = alloc_sum - release_sum;
			pending.push_back(r);
		endfunction

		function void check_report(report_t got);
			report_t w;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction");
				return;
			end
			w = pending.pop_front();
			if (got != w) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp st=%0d os=%0h lv=%0d pk=%0d tc=%0h ba=%0h bf=%0h bo=%0h",
						w.status, w.old_size, w.live, w.peak, w.total, w.allocated,
						w.released, w.outstanding);
					$display("         got st=%0d os=%0h lv=%0d pk=%0d tc=%0h ba=%0h bf=%0h bo=%0h",
						got.status, got.old_size, got.live, got.peak, got.total,
						got.allocated, got.released, got.outstanding);
				end
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [207:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [327:0] m_tdata;
	logic [1:0]   m_tuser;

	allocation_tracker_table_unit i_dut (.*);

	tracker_scoreboard tracker;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	logic [63:0] addr_pool [$];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_event(event_t ev);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_tvalid <= 1;
		s_tuser <= ev.op;
		s_tdata <= {ev.count, ev.size, ev.old_addr, ev.new_addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_event(ev);
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	task automatic do_event(att_pkg::op_t op, logic [63:0] na, logic [63:0] oa,
			logic [47:0] sz, logic [31:0] cnt);
		event_t ev;
		ev.op = op;
		ev.new_addr = na;
		ev.old_addr = oa;
		ev.size = sz;
		ev.count = cnt;
		send_event(ev);
		if (op != att_pkg::OP_FREE) addr_pool.push_back(na);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] known_addr();
		if (addr_pool.size() == 0) return rand64();
		return addr_pool[$urandom_range(addr_pool.size() - 1)];
	endfunction

	task automatic random_event();
		int k;
		logic [63:0] a, b;
		logic [47:0] sz;
		k = $urandom_range(99);
		sz = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) : 48'($urandom_range(4096));
		a = ($urandom_range(19) == 0) ? rand64() : {32'h7f00_0000, $urandom & 32'hffff_fff0};
		if (k < 35) do_event(att_pkg::OP_MALLOC, a, rand64(), sz, $urandom);
		else if (k < 45) do_event(att_pkg::OP_CALLOC, a, rand64(),
			($urandom_range(7) == 0) ? 48'({$urandom, $urandom}) : 48'($urandom_range(64)),
			($urandom_range(7) == 0) ? $urandom : $urandom_range(16));
		else if (k < 75) begin
			b = ($urandom_range(9) == 0) ? rand64() : known_addr();
			do_event(att_pkg::OP_FREE, rand64(), b, sz, $urandom);
		end else begin
			b = known_addr();
			case ($urandom_range(3))
				0: do_event(att_pkg::OP_REALLOC, b, b, sz, $urandom);
				1: do_event(att_pkg::OP_REALLOC, a, 64'd0, sz, $urandom);
				default: do_event(att_pkg::OP_REALLOC, a, b, sz, $urandom);
			endcase
		end
	endtask

	task automatic wait_drained();
		while (tracker.pending.size() != 0) @(negedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		report_t got;
		if (m_tvalid && m_tready) begin
			got.status = att_pkg::status_t'(m_tuser);
			got.old_size = m_tdata[47:0];
			got.live = m_tdata[59:48];
			got.peak = m_tdata[71:60];
			got.total = m_tdata[135:72];
			got.allocated = m_tdata[199:136];
			got.released = m_tdata[263:200];
			got.outstanding = m_tdata[327:264];
			tracker.check_report(got);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) m_tready <= 0;
		else m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		tracker = new();
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = att_pkg::OP_MALLOC;
		m_tready = 0;
		recv_hold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: field extremes, every op, untracked free, realloc cases, calloc saturation
		do_event(att_pkg::OP_MALLOC, 64'd0, 64'd0, 48'd0, 32'd0);
		do_event(att_pkg::OP_MALLOC, '1, '1, '1, '1);
		do_event(att_pkg::OP_MALLOC, 64'h1000, 64'd0, 48'd100, 32'd0);
		do_event(att_pkg::OP_MALLOC, 64'h1000, 64'd0, 48'd7, 32'd0);
		do_event(att_pkg::OP_CALLOC, 64'h2000, 64'd0, 48'd16, 32'd10);
		do_event(att_pkg::OP_CALLOC, 64'h3000, 64'd0, '1, '1);
		do_event(att_pkg::OP_CALLOC, 64'h4000, 64'd0, 48'd5, 32'd0);
		do_event(att_pkg::OP_FREE, 64'd0, 64'h1000, 48'd0, 32'd0);
		do_event(att_pkg::OP_FREE, 64'd0, 64'h1000, 48'd0, 32'd0);
		do_event(att_pkg::OP_FREE, 64'd0, 64'h1000, 48'd0, 32'd0);
		do_event(att_pkg::OP_FREE, 64'd0, 64'hdead, 48'd0, 32'd0);
		do_event(att_pkg::OP_REALLOC, 64'h2000, 64'h2000, 48'd500, 32'd0);
		do_event(att_pkg::OP_REALLOC, 64'h2000, 64'h2000, 48'd3, 32'd0);
		do_event(att_pkg::OP_REALLOC, 64'h5000, 64'h2000, 48'd64, 32'd0);
		do_event(att_pkg::OP_REALLOC, 64'h6000, 64'd0, 48'd8, 32'd0);
		do_event(att_pkg::OP_REALLOC, 64'h7000, 64'h9999, 48'd9, 32'd0);
		do_event(att_pkg::OP_FREE, 64'd0, '1, 48'd0, 32'd0);
		do_event(att_pkg::OP_FREE, 64'd0, 64'd0, 48'd0, 32'd0);

		// fill part of the table with the receiver held off for a while
		fork
			begin
				recv_hold = 1;
				repeat (400) @(negedge clk);
				recv_hold = 0;
			end
			for (int i = 0; i < 60; i++)
				do_event(att_pkg::OP_MALLOC, {32'h5500_0000, $urandom}, 64'd0,
					48'($urandom_range(256)), 32'd0);
		join
		for (int i = 0; i < 20; i++) random_event();
		wait_drained();

		// empty most of it again
		while (tracker.live_now > 40)
			do_event(att_pkg::OP_FREE, 64'd0, known_addr(), 48'd0, 32'd0);
		addr_pool.delete();
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 64 : 0;
			recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 9 : 0;
			for (int i = 0; i < 230; i++) random_event();
			wait_drained();
		end

		fork
			wait_drained();
			begin
				repeat (200000) @(negedge clk);
			end
		join_any
		disable fork;
		repeat (100) @(negedge clk);
		if (tracker.pending.size() == 0 && tracker.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
src/att_pkg.sv
src/att_hash.sv
src/att_table.sv
src/allocation_tracker_table_unit.sv
dv/tb_allocation_tracker_table_unit.sv
